FILE: src/layer_priority_window_blender_assert.svh
// ----------------------------------------------------------------------------
// Layer compositor assertion macros
// Shared wrappers for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LAYER_PRIORITY_WINDOW_BLENDER_ASSERT_SVH
`define LAYER_PRIORITY_WINDOW_BLENDER_ASSERT_SVH

// Same-cycle implication
`define LPWB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LPWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lpwb_pkg.sv
// ----------------------------------------------------------------------------
// lpwb_pkg
// Types, constants and color helpers for the layer compositor.
// ----------------------------------------------------------------------------
package lpwb_pkg;

  localparam logic [2:0] PRIO_EMPTY  = 3'd5;
  localparam logic [2:0] ID_OBJ      = 3'd4;
  localparam logic [2:0] ID_BACKDROP = 3'd5;

  localparam int unsigned MASK_OBJ    = 4;
  localparam int unsigned MASK_EFFECT = 5;
  localparam logic [5:0]  MASK_ALL    = 6'h3F;

  localparam logic [4:0] WEIGHT_MAX = 5'd16;
  localparam logic [7:0] CHAN_MAX   = 8'd255;

  typedef enum logic [2:0] {
    REG_WINDOW_ENABLES     = 3'd0,
    REG_BLEND_CONTROL      = 3'd1,
    REG_BLEND_ALPHA        = 3'd2,
    REG_BLEND_BRIGHTNESS   = 3'd3,
    REG_WINDOW0_BOUNDS     = 3'd4,
    REG_WINDOW1_BOUNDS     = 3'd5,
    REG_WINDOW_LAYER_MASKS = 3'd6,
    REG_BACKDROP_COLOR     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_ALPHA    = 2'd1,
    MODE_BRIGHTEN = 2'd2,
    MODE_DARKEN   = 2'd3
  } blend_mode_t;

  typedef struct packed {
    logic [2:0]  window_enables;
    logic [13:0] blend_control;
    logic [12:0] blend_alpha;
    logic [4:0]  blend_brightness;
    logic [31:0] window0_bounds;
    logic [31:0] window1_bounds;
    logic [17:0] window_layer_masks;
    logic [14:0] backdrop_color;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  pixel_x;
    logic [7:0]  line;
    logic [14:0] obj_color;
    logic [2:0]  obj_priority;
    logic [14:0] bg0_color;
    logic [2:0]  bg0_priority;
    logic [14:0] bg1_color;
    logic [2:0]  bg1_priority;
    logic [14:0] bg2_color;
    logic [2:0]  bg2_priority;
    logic [14:0] bg3_color;
    logic [2:0]  bg3_priority;
  } pix_t;

  // Result of layer selection, colors already widened to RGB888
  typedef struct packed {
    logic [23:0] front_color;
    logic [2:0]  top_id;
    logic [23:0] back_color;
    logic [2:0]  bot_id;
  } sel_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  // RGB555 (red in low bits) to RGB888 (red in high byte)
  function automatic logic [23:0] widen555(input logic [14:0] c);
    return {widen5(c[4:0]), widen5(c[9:5]), widen5(c[14:10])};
  endfunction

  function automatic logic [4:0] clamp16(input logic [4:0] v);
    return (v > WEIGHT_MAX) ? WEIGHT_MAX : v;
  endfunction

endpackage

FILE: src/lpwb_if.sv
// ----------------------------------------------------------------------------
// lpwb channel interfaces
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface lpwb_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_x;
  logic [7:0]  line;
  logic [14:0] obj_color;
  logic [2:0]  obj_priority;
  logic [14:0] bg0_color;
  logic [2:0]  bg0_priority;
  logic [14:0] bg1_color;
  logic [2:0]  bg1_priority;
  logic [14:0] bg2_color;
  logic [2:0]  bg2_priority;
  logic [14:0] bg3_color;
  logic [2:0]  bg3_priority;

  modport source (
    output valid, pixel_x, line, obj_color, obj_priority, bg0_color, bg0_priority,
           bg1_color, bg1_priority, bg2_color, bg2_priority, bg3_color, bg3_priority,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, line, obj_color, obj_priority, bg0_color, bg0_priority,
           bg1_color, bg1_priority, bg2_color, bg2_priority, bg3_color, bg3_priority,
    output ready
  );
endinterface

interface lpwb_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] out_color;

  modport source (output valid, out_color, input ready);
  modport sink (input valid, out_color, output ready);
endinterface

interface lpwb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/lpwb_window.sv
// ----------------------------------------------------------------------------
// lpwb_window
// Window hit test; picks the 6-bit layer/effect mask for one pixel.
// ----------------------------------------------------------------------------
module lpwb_window
  import lpwb_pkg::*;
(
  input  cfg_t       cfg,
  input  logic [7:0] pixel_x,
  input  logic [7:0] line,
  output logic [5:0] mask
);

  function automatic logic in_span(input logic [7:0] c, input logic [7:0] lo,
                                   input logic [7:0] hi);
    if (lo <= hi) begin
      return (c >= lo) && (c < hi);
    end
    return (c >= lo) || (c < hi);
  endfunction

  function automatic logic in_win(input logic [31:0] b, input logic [7:0] x,
                                  input logic [7:0] y);
    return in_span(x, b[15:8], b[7:0]) && in_span(y, b[31:24], b[23:16]);
  endfunction

  logic hit0;
  logic hit1;

  assign hit0 = cfg.window_enables[0] && in_win(cfg.window0_bounds, pixel_x, line);
  assign hit1 = cfg.window_enables[1] && in_win(cfg.window1_bounds, pixel_x, line);

  always_comb begin
    priority if (cfg.window_enables == 3'b000) begin
      mask = MASK_ALL;
    end else if (hit0) begin
      mask = cfg.window_layer_masks[5:0];
    end else if (hit1) begin
      mask = cfg.window_layer_masks[11:6];
    end else begin
      // object window never hits; outside mask
      mask = cfg.window_layer_masks[17:12];
    end
  end

endmodule

FILE: src/lpwb_layer_sel.sv
// ----------------------------------------------------------------------------
// lpwb_layer_sel
// Picks top and second layer among enabled, opaque layers.
// ----------------------------------------------------------------------------
module lpwb_layer_sel
  import lpwb_pkg::*;
(
  input  pix_t        pix,
  input  logic [5:0]  mask,
  input  logic [14:0] backdrop_color,
  output sel_t        sel
);

  logic [23:0] bg_c [4];
  logic [2:0]  bg_p [4];
  logic [23:0] obj_c;
  logic [2:0]  top_p;

  assign bg_c[0] = widen555(pix.bg0_color);
  assign bg_c[1] = widen555(pix.bg1_color);
  assign bg_c[2] = widen555(pix.bg2_color);
  assign bg_c[3] = widen555(pix.bg3_color);
  assign bg_p[0] = pix.bg0_priority;
  assign bg_p[1] = pix.bg1_priority;
  assign bg_p[2] = pix.bg2_priority;
  assign bg_p[3] = pix.bg3_priority;
  assign obj_c   = widen555(pix.obj_color);

  always_comb begin
    sel.front_color = widen555(backdrop_color);
    sel.back_color  = sel.front_color;
    sel.top_id      = ID_BACKDROP;
    sel.bot_id      = ID_BACKDROP;
    top_p           = PRIO_EMPTY;

    if (mask[MASK_OBJ] && pix.obj_priority < top_p) begin
      top_p           = pix.obj_priority;
      sel.front_color = obj_c;
      sel.top_id      = ID_OBJ;
    end

    // BG0..BG3 in order: a front layer pushes the old top down, an opaque
    // layer behind it overwrites the second slot
    for (int b = 0; b < 4; b++) begin
      if (mask[b]) begin
        if (bg_p[b] < top_p) begin
          sel.back_color  = sel.front_color;
          sel.bot_id      = sel.top_id;
          top_p           = bg_p[b];
          sel.front_color = bg_c[b];
          sel.top_id      = 3'(b);
        end else if (bg_p[b] < PRIO_EMPTY) begin
          sel.back_color = bg_c[b];
          sel.bot_id     = 3'(b);
        end
      end
    end

    if (sel.top_id != ID_OBJ && mask[MASK_OBJ] && pix.obj_priority < PRIO_EMPTY &&
        pix.obj_priority >= top_p) begin
      sel.back_color = obj_c;
      sel.bot_id     = ID_OBJ;
    end
  end

endmodule

FILE: src/lpwb_effect.sv
// ----------------------------------------------------------------------------
// lpwb_effect
// Alpha blend, brighten and darken on RGB888 channels.
// ----------------------------------------------------------------------------
module lpwb_effect
  import lpwb_pkg::*;
(
  input  cfg_t        cfg,
  input  sel_t        sel,
  input  logic        effect_en,
  output logic [23:0] color
);

  blend_mode_t mode;
  logic [5:0]  first_tgt;
  logic [5:0]  second_tgt;
  logic [4:0]  wa;
  logic [4:0]  wb;
  logic [4:0]  f;
  logic        is_first;
  logic        is_second;
  logic [23:0] alpha_c;
  logic [23:0] bright_c;
  logic [23:0] dark_c;

  assign mode       = blend_mode_t'(cfg.blend_control[7:6]);
  assign first_tgt  = cfg.blend_control[5:0];
  assign second_tgt = cfg.blend_control[13:8];
  assign wa         = clamp16(cfg.blend_alpha[4:0]);
  assign wb         = clamp16(cfg.blend_alpha[12:8]);
  assign f          = clamp16(cfg.blend_brightness);
  assign is_first   = first_tgt[sel.top_id];
  assign is_second  = second_tgt[sel.bot_id];

  always_comb begin
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [13:0] sum;
    logic [9:0]  q;
    logic [12:0] prod;
    for (int k = 0; k < 3; k++) begin
      c1  = sel.front_color[8*k +: 8];
      c2  = sel.back_color[8*k +: 8];
      sum = 14'(c1 * wa) + 14'(c2 * wb);
      q   = sum[13:4];
      alpha_c[8*k +: 8] = (q > 10'(CHAN_MAX)) ? CHAN_MAX : q[7:0];
      prod = 13'((CHAN_MAX - c1) * f);
      bright_c[8*k +: 8] = c1 + prod[11:4];
      prod = 13'(c1 * f);
      dark_c[8*k +: 8] = c1 - prod[11:4];
    end
  end

  always_comb begin
    color = sel.front_color;
    if (effect_en && is_first) begin
      unique case (mode)
        MODE_ALPHA: begin
          if (is_second) begin
            color = alpha_c;
          end
        end
        MODE_BRIGHTEN: color = bright_c;
        MODE_DARKEN:   color = dark_c;
        MODE_NONE:     color = sel.front_color;
      endcase
    end
  end

endmodule

FILE: src/layer_priority_window_blender.sv
// ----------------------------------------------------------------------------
// layer_priority_window_blender
// Per-pixel compositor: window mask, layer priority, color effects, RGB888.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                     | accept
//  --------+-----+---------------------------------------------+-------------
//  pix     | in  | pixel_x, line, obj/bg0..bg3 color+priority  | valid&ready
//  res     | out | out_color (RGB888, red in 23:16)            | valid&ready
//  cfg     | in  | index (register), data                      | valid&ready
//
//  One pixel word per clock while res is taken; input reg, then result reg.
//  All compositing sits between those two registers in one pass.
//  cfg is always ready; writes take effect on the next cycle.
//  Synchronous reset clears the config registers and both valid flags.
//  A stalled result holds; the input register still fills behind it.
// ----------------------------------------------------------------------------
`include "layer_priority_window_blender_assert.svh"

module layer_priority_window_blender
  import lpwb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  lpwb_cfg_if.sink   cfg,
  lpwb_pix_if.sink   pix,
  lpwb_res_if.source res
);

  cfg_t        regs;
  pix_t        s1_pix;
  logic        s1_valid;
  logic        o_valid;
  logic [23:0] out_color;
  logic        advance;
  logic [5:0]  win_mask;
  sel_t        sel;
  logic [23:0] color_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_WINDOW_ENABLES:     regs.window_enables     <= cfg.data[2:0];
        REG_BLEND_CONTROL:      regs.blend_control      <= cfg.data[13:0];
        REG_BLEND_ALPHA:        regs.blend_alpha        <= cfg.data[12:0];
        REG_BLEND_BRIGHTNESS:   regs.blend_brightness   <= cfg.data[4:0];
        REG_WINDOW0_BOUNDS:     regs.window0_bounds     <= cfg.data;
        REG_WINDOW1_BOUNDS:     regs.window1_bounds     <= cfg.data;
        REG_WINDOW_LAYER_MASKS: regs.window_layer_masks <= cfg.data[17:0];
        REG_BACKDROP_COLOR:     regs.backdrop_color     <= cfg.data[14:0];
      endcase
    end
  end

  assign advance   = !o_valid || res.ready;
  assign pix.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (pix.ready) begin
        s1_valid <= pix.valid;
      end
      if (advance) begin
        o_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix.ready && pix.valid) begin
      s1_pix <= '{pixel_x:      pix.pixel_x,
                  line:         pix.line,
                  obj_color:    pix.obj_color,
                  obj_priority: pix.obj_priority,
                  bg0_color:    pix.bg0_color,
                  bg0_priority: pix.bg0_priority,
                  bg1_color:    pix.bg1_color,
                  bg1_priority: pix.bg1_priority,
                  bg2_color:    pix.bg2_color,
                  bg2_priority: pix.bg2_priority,
                  bg3_color:    pix.bg3_color,
                  bg3_priority: pix.bg3_priority};
    end
    if (advance && s1_valid) begin
      out_color <= color_next;
    end
  end

  lpwb_window u_window (
    .cfg     (regs),
    .pixel_x (s1_pix.pixel_x),
    .line    (s1_pix.line),
    .mask    (win_mask)
  );

  lpwb_layer_sel u_layer_sel (
    .pix            (s1_pix),
    .mask           (win_mask),
    .backdrop_color (regs.backdrop_color),
    .sel            (sel)
  );

  lpwb_effect u_effect (
    .cfg       (regs),
    .sel       (sel),
    .effect_en (win_mask[MASK_EFFECT]),
    .color     (color_next)
  );

  assign res.valid     = o_valid;
  assign res.out_color = out_color;

  `LPWB_ASSERT_NEXT(a_stage_moves, s1_valid && advance, o_valid,
                    "pixel in input register lost on advance")
  `LPWB_ASSERT_NOW(a_ready_low_full, !pix.ready, s1_valid && o_valid && !res.ready,
                   "input stalled while pipeline has room")
  `LPWB_ASSERT_NOW(a_no_window_mask, s1_valid && regs.window_enables == 3'b000,
                   win_mask == MASK_ALL, "windowing off but mask restricted")

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the layer compositor. Pixels go in through a
// queue-fed driver with random gaps, results come back under random stalls
// and one long hold-off. A local compositing model predicts each RGB888 word
// from the register settings seen on the config port.
// ----------------------------------------------------------------------------
module tb_top;
  import lpwb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst;

  lpwb_cfg_if cfg();
  lpwb_pix_if pix();
  lpwb_res_if res();

  layer_priority_window_blender u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .pix (pix),
    .res (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pix_t        pixel_queue[$];
  logic [23:0] expected_colors[$];
  cfg_t        cfg_model;
  int          errors = 0;
  int          cycle_count = 0;
  int          src_gap;
  int          sink_wait;
  int          hold_left;
  int          hold_requests = 0;
  int          hold_served;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;

  // ---------------------------------------------------------------------------
  // Compositing model
  // ---------------------------------------------------------------------------
  function automatic logic [23:0] expand_rgb555(logic [14:0] c);
    logic [4:0] r, g, b;
    r = c[4:0];
    g = c[9:5];
    b = c[14:10];
    return {r, r[4:2], g, g[4:2], b, b[4:2]};
  endfunction

  function automatic bit span_hit(logic [7:0] coord, logic [7:0] lo, logic [7:0] hi);
    if (lo <= hi) return coord >= lo && coord < hi;
    return coord >= lo || coord < hi;
  endfunction

  // bounds bytes, low to high: x2, x1, y2, y1
  function automatic bit window_hit(logic [31:0] bounds, logic [7:0] x, logic [7:0] y);
    return span_hit(x, bounds[15:8], bounds[7:0]) && span_hit(y, bounds[31:24], bounds[23:16]);
  endfunction

  function automatic logic [5:0] layer_mask(logic [7:0] x, logic [7:0] y);
    if (cfg_model.window_enables == 3'b000) return MASK_ALL;
    if (cfg_model.window_enables[0] && window_hit(cfg_model.window0_bounds, x, y))
      return cfg_model.window_layer_masks[5:0];
    if (cfg_model.window_enables[1] && window_hit(cfg_model.window1_bounds, x, y))
      return cfg_model.window_layer_masks[11:6];
    // object window never hits by itself
    return cfg_model.window_layer_masks[17:12];
  endfunction

  function automatic logic [23:0] composite_pixel(pix_t p);
    logic [5:0]  mask;
    logic [23:0] top_c, bot_c, obj_c, c, fx;
    logic [2:0]  top_p, top_id, bot_id;
    logic [14:0] bg_col[4];
    logic [2:0]  bg_pri[4];
    int          wa, wb, f, t, s, v;
    blend_mode_t mode;

    mask   = layer_mask(p.pixel_x, p.line);
    top_c  = expand_rgb555(cfg_model.backdrop_color);
    bot_c  = top_c;
    top_p  = PRIO_EMPTY;
    top_id = ID_BACKDROP;
    bot_id = ID_BACKDROP;
    obj_c  = expand_rgb555(p.obj_color);
    bg_col = '{p.bg0_color, p.bg1_color, p.bg2_color, p.bg3_color};
    bg_pri = '{p.bg0_priority, p.bg1_priority, p.bg2_priority, p.bg3_priority};

    if (mask[MASK_OBJ] && p.obj_priority < top_p) begin
      top_p  = p.obj_priority;
      top_c  = obj_c;
      top_id = ID_OBJ;
    end
    for (int i = 0; i < 4; i++) begin
      if (!mask[i]) continue;
      c = expand_rgb555(bg_col[i]);
      if (bg_pri[i] < top_p) begin
        bot_c  = top_c;
        bot_id = top_id;
        top_p  = bg_pri[i];
        top_c  = c;
        top_id = 3'(i);
      end else if (bg_pri[i] < PRIO_EMPTY) begin
        bot_c  = c;
        bot_id = 3'(i);
      end
    end
    // a sprite behind the top layer still shows up as second layer
    if (top_id != ID_OBJ && mask[MASK_OBJ] && p.obj_priority < PRIO_EMPTY &&
        p.obj_priority >= top_p) begin
      bot_c  = obj_c;
      bot_id = ID_OBJ;
    end

    if (!mask[MASK_EFFECT] || !cfg_model.blend_control[top_id]) return top_c;

    mode = blend_mode_t'(cfg_model.blend_control[7:6]);
    wa = int'(cfg_model.blend_alpha[4:0]);
    wb = int'(cfg_model.blend_alpha[12:8]);
    f  = int'(cfg_model.blend_brightness);
    if (wa > 16) wa = 16;
    if (wb > 16) wb = 16;
    if (f > 16) f = 16;
    fx = '0;
    case (mode)
      MODE_ALPHA: begin
        if (!cfg_model.blend_control[8 + bot_id]) return top_c;
        for (int k = 0; k < 3; k++) begin
          t = int'(top_c[8*k +: 8]);
          s = int'(bot_c[8*k +: 8]);
          v = (t * wa + s * wb) / 16;
          if (v > 255) v = 255;
          fx[8*k +: 8] = v[7:0];
        end
      end
      MODE_BRIGHTEN: begin
        for (int k = 0; k < 3; k++) begin
          t = int'(top_c[8*k +: 8]);
          v = t + (255 - t) * f / 16;
          fx[8*k +: 8] = v[7:0];
        end
      end
      MODE_DARKEN: begin
        for (int k = 0; k < 3; k++) begin
          t = int'(top_c[8*k +: 8]);
          v = t - t * f / 16;
          fx[8*k +: 8] = v[7:0];
        end
      end
      default: return top_c;
    endcase
    return fx;
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    pix_t nxt;
    if (rst) begin
      pix.valid <= 1'b0;
      src_gap   <= 0;
    end else if (!pix.valid || pix.ready) begin
      if (src_gap > 0) begin
        pix.valid <= 1'b0;
        src_gap   <= src_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        nxt = pixel_queue.pop_front();
        pix.valid <= 1'b1;
        {pix.pixel_x, pix.line, pix.obj_color, pix.obj_priority,
         pix.bg0_color, pix.bg0_priority, pix.bg1_color, pix.bg1_priority,
         pix.bg2_color, pix.bg2_priority, pix.bg3_color, pix.bg3_priority} <= nxt;
        src_gap <= src_steady ? 0 : $urandom_range(0, 3);
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  always @(posedge clk) begin : result_sink
    int w;
    if (rst) begin
      res.ready <= 1'b0;
      sink_wait <= 0;
    end else if (hold_left > 0) begin
      res.ready <= 1'b0;
    end else if (res.valid && res.ready) begin
      w = sink_steady ? 0 : $urandom_range(0, 3);
      sink_wait <= w;
      res.ready <= (w == 0);
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      res.ready <= (sink_wait == 1);
    end else begin
      res.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: register shadow, result check, prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    logic [23:0] want;
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_WINDOW_ENABLES:     cfg_model.window_enables     = cfg.data[2:0];
          REG_BLEND_CONTROL:      cfg_model.blend_control      = cfg.data[13:0];
          REG_BLEND_ALPHA:        cfg_model.blend_alpha        = cfg.data[12:0];
          REG_BLEND_BRIGHTNESS:   cfg_model.blend_brightness   = cfg.data[4:0];
          REG_WINDOW0_BOUNDS:     cfg_model.window0_bounds     = cfg.data;
          REG_WINDOW1_BOUNDS:     cfg_model.window1_bounds     = cfg.data;
          REG_WINDOW_LAYER_MASKS: cfg_model.window_layer_masks = cfg.data[17:0];
          REG_BACKDROP_COLOR:     cfg_model.backdrop_color     = cfg.data[14:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (expected_colors.size() == 0) begin
          $error("out_color: expected none, actual %06h", res.out_color);
          errors++;
        end else begin
          want = expected_colors.pop_front();
          if (res.out_color !== want) begin
            $error("out_color: expected %06h, actual %06h", want, res.out_color);
            errors++;
          end
        end
      end
      if (pix.valid && pix.ready)
        expected_colors.push_back(composite_pixel(pix_t'({pix.pixel_x, pix.line,
          pix.obj_color, pix.obj_priority, pix.bg0_color, pix.bg0_priority,
          pix.bg1_color, pix.bg1_priority, pix.bg2_color, pix.bg2_priority,
          pix.bg3_color, pix.bg3_priority})));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic program_cfg(cfg_t c);
    write_reg(REG_WINDOW_ENABLES, 32'(c.window_enables));
    write_reg(REG_BLEND_CONTROL, 32'(c.blend_control));
    write_reg(REG_BLEND_ALPHA, 32'(c.blend_alpha));
    write_reg(REG_BLEND_BRIGHTNESS, 32'(c.blend_brightness));
    write_reg(REG_WINDOW0_BOUNDS, c.window0_bounds);
    write_reg(REG_WINDOW1_BOUNDS, c.window1_bounds);
    write_reg(REG_WINDOW_LAYER_MASKS, 32'(c.window_layer_masks));
    write_reg(REG_BACKDROP_COLOR, 32'(c.backdrop_color));
    cfg.valid <= 1'b0;
  endtask

  // sample on the falling edge so every clocked update has settled,
  // then hand back on a rising edge for the next drive
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || pix.valid || expected_colors.size() != 0);
    @(posedge clk);
  endtask

  function automatic pix_t flat_pixel(int x, int y, logic [14:0] col, logic [2:0] pri);
    return pix_t'({x[7:0], y[7:0], col, pri, col, pri, col, pri, col, pri, col, pri});
  endfunction

  function automatic logic [2:0] random_priority();
    if ($urandom_range(0, 3) == 0) return 3'($urandom_range(5, 7));
    return 3'($urandom_range(0, 4));
  endfunction

  function automatic pix_t random_pixel();
    pix_t p;
    p.pixel_x      = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 239));
    p.line         = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 159));
    p.obj_color    = 15'($urandom);
    p.obj_priority = random_priority();
    p.bg0_color    = 15'($urandom);
    p.bg0_priority = random_priority();
    p.bg1_color    = 15'($urandom);
    p.bg1_priority = random_priority();
    p.bg2_color    = 15'($urandom);
    p.bg2_priority = random_priority();
    p.bg3_color    = 15'($urandom);
    p.bg3_priority = random_priority();
    return p;
  endfunction

  function automatic logic [31:0] random_bounds();
    logic [7:0] x1, x2, y1, y2;
    x1 = 8'($urandom_range(0, 255));
    x2 = ($urandom_range(0, 7) == 0) ? x1 : 8'($urandom_range(0, 255));
    y1 = 8'($urandom_range(0, 255));
    y2 = ($urandom_range(0, 7) == 0) ? y1 : 8'($urandom_range(0, 255));
    return {y1, y2, x1, x2};
  endfunction

  // upper data bits beyond each register's width are left random on purpose
  task automatic run_random_phase(int count, bit steady_src, bit steady_sink, bit with_hold);
    src_steady  = steady_src;
    sink_steady = steady_sink;
    write_reg(REG_WINDOW_ENABLES, $urandom);
    write_reg(REG_BLEND_CONTROL, $urandom);
    write_reg(REG_BLEND_ALPHA, $urandom);
    write_reg(REG_BLEND_BRIGHTNESS, $urandom);
    write_reg(REG_WINDOW0_BOUNDS, random_bounds());
    write_reg(REG_WINDOW1_BOUNDS, random_bounds());
    write_reg(REG_WINDOW_LAYER_MASKS, $urandom);
    write_reg(REG_BACKDROP_COLOR, $urandom);
    cfg.valid <= 1'b0;
    for (int i = 0; i < count; i++) pixel_queue.push_back(random_pixel());
    if (with_hold) hold_requests++;
    wait_drained();
  endtask

  initial begin : stimulus
    pix_t p;
    cfg_t setup;
    rst       = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    {pix.valid, pix.pixel_x, pix.line, pix.obj_color, pix.obj_priority,
     pix.bg0_color, pix.bg0_priority, pix.bg1_color, pix.bg1_priority,
     pix.bg2_color, pix.bg2_priority, pix.bg3_color, pix.bg3_priority} = '0;
    res.ready = 1'b0;
    cfg_model = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no windows, no effect, black backdrop
    pixel_queue.push_back(flat_pixel(0, 0, 15'h0000, 3'd5));
    p = flat_pixel(239, 159, 15'h7FFF, 3'd0);
    p.obj_color = 15'h001F;
    pixel_queue.push_back(p);
    p = flat_pixel(255, 255, 15'h1234, 3'd7);
    p.obj_priority = 3'd4;
    p.bg2_priority = 3'd6;
    pixel_queue.push_back(p);
    p = flat_pixel(120, 80, 15'h5555, 3'd3);
    p.bg3_priority = 3'd1;
    p.obj_priority = 3'd2;
    p.bg0_priority = 3'd4;
    pixel_queue.push_back(p);
    wait_drained();

    // wrapping window 0, alpha blend with clamped weights
    setup = '0;
    setup.window_enables     = 3'b001;
    setup.window0_bounds     = {8'd150, 8'd10, 8'd200, 8'd40};
    setup.window_layer_masks = {6'h10, 6'h00, 6'h3F};
    setup.blend_control      = {6'h3F, MODE_ALPHA, 6'h3F};
    setup.blend_alpha        = {5'd31, 3'd0, 5'd31};
    setup.backdrop_color     = 15'h7FFF;
    program_cfg(setup);
    p = flat_pixel(220, 155, 15'h7FFF, 3'd5);
    p.obj_priority = 3'd0;
    p.bg1_priority = 3'd1;
    pixel_queue.push_back(p);
    p.pixel_x = 10;  p.line = 5;   pixel_queue.push_back(p);
    p.pixel_x = 100; p.line = 80;  pixel_queue.push_back(p);
    p.pixel_x = 40;  p.line = 5;   pixel_queue.push_back(p);
    p.pixel_x = 200; p.line = 10;  pixel_queue.push_back(p);
    p.pixel_x = 200; p.line = 9;   pixel_queue.push_back(p);
    wait_drained();

    // window 1 plus object window, full brighten
    setup.window_enables     = 3'b110;
    setup.window1_bounds     = {8'd16, 8'd64, 8'd16, 8'd64};
    setup.window_layer_masks = {6'h00, 6'h2F, 6'h3F};
    setup.blend_control      = {6'h00, MODE_BRIGHTEN, 6'h21};
    setup.blend_alpha        = '0;
    setup.blend_brightness   = 5'd31;
    setup.backdrop_color     = 15'h2108;
    program_cfg(setup);
    p = flat_pixel(16, 16, 15'h4A52, 3'd5);
    p.bg0_priority = 3'd2;
    pixel_queue.push_back(p);
    pixel_queue.push_back(flat_pixel(63, 63, 15'h1111, 3'd5));
    pixel_queue.push_back(flat_pixel(64, 16, 15'h3333, 3'd1));
    pixel_queue.push_back(flat_pixel(15, 63, 15'h3333, 3'd1));
    wait_drained();

    // empty window 0 and object window only, darken
    setup.window_enables     = 3'b101;
    setup.window0_bounds     = {8'd0, 8'd160, 8'd100, 8'd100};
    setup.window_layer_masks = {6'h3F, 6'h00, 6'h00};
    setup.blend_control      = {6'h3F, MODE_DARKEN, 6'h3F};
    setup.blend_brightness   = 5'd8;
    program_cfg(setup);
    p = flat_pixel(100, 50, 15'h7FFF, 3'd4);
    p.bg2_priority = 3'd3;
    pixel_queue.push_back(p);
    pixel_queue.push_back(flat_pixel(0, 0, 15'h7C1F, 3'd6));
    p = flat_pixel(230, 150, 15'h03E0, 3'd2);
    p.obj_priority = 3'd1;
    pixel_queue.push_back(p);
    wait_drained();

    // alpha mode with no second target: top color passes
    setup.blend_control = {6'h00, MODE_ALPHA, 6'h3F};
    program_cfg(setup);
    pixel_queue.push_back(flat_pixel(50, 50, 15'h6B5A, 3'd0));
    p = flat_pixel(51, 50, 15'h0421, 3'd5);
    p.bg3_priority = 3'd2;
    pixel_queue.push_back(p);
    wait_drained();

    // every register at its top value
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), '1);
    cfg.valid <= 1'b0;
    for (int i = 0; i < 100; i++) pixel_queue.push_back(random_pixel());
    wait_drained();

    for (int ph = 0; ph < 10; ph++)
      run_random_phase(110, ph == 2 || ph == 5, ph == 5 || ph == 7, ph == 3);

    src_steady  = 1'b0;
    sink_steady = 1'b0;
    program_cfg('0);
    for (int i = 0; i < 40; i++) pixel_queue.push_back(random_pixel());
    wait_drained();

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: layer_priority_window_blender.f
+incdir+src
src/lpwb_pkg.sv
src/lpwb_if.sv
src/lpwb_window.sv
src/lpwb_layer_sel.sv
src/lpwb_effect.sv
src/layer_priority_window_blender.sv
test/tb_top.sv
